// ===== hw/rtl/ptsb_pkg.sv =====
// ptsb_pkg: shared types, constants and the atan table for the point-to-scan binning block
// no dependencies

package ptsb_pkg;

  localparam int MAX_BINS_DEF     = 1024;
  localparam int CORDIC_STEPS_DEF = 20;

  localparam int CW = 24;
  localparam int AW = 17;
  localparam int TW = 8;
  localparam int BW = 10;
  localparam int SW = 49;
  localparam int KW = 3;

  localparam logic [CW-1:0] NO_RET = 24'hFFFFFF;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_HEIGHT_LOW  = 3'd0,
    REG_HEIGHT_HIGH = 3'd1,
    REG_RANGE_LOW   = 3'd2,
    REG_RANGE_HIGH  = 3'd3,
    REG_ANGLE_START = 3'd4,
    REG_ANGLE_END   = 3'd5,
    REG_ANGLE_STEP  = 3'd6,
    REG_TAG_FILTER  = 3'd7
  } reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_SQUARE,
    ST_CHECK,
    ST_ITER,
    ST_ANGLE,
    ST_BINS,
    ST_INDEX,
    ST_READ,
    ST_WRITE,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic square;
    logic init_iter;
    logic iter;
    logic angle;
    logic div_start;
    logic div_step;
    logic bin_pick;
    logic mem_rd;
    logic mem_wr;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic is_read;
    logic drop_early;
    logic drop_angle;
    logic iter_done;
    logic div_done;
    logic div_second;
  } stat_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    begin
      unique case (i)
        5'd0:  t = 32'h20000000;
        5'd1:  t = 32'h12E4051E;
        5'd2:  t = 32'h09FB385B;
        5'd3:  t = 32'h051111D4;
        5'd4:  t = 32'h028B0D43;
        5'd5:  t = 32'h0145D7E1;
        5'd6:  t = 32'h00A2F61E;
        5'd7:  t = 32'h00517C55;
        5'd8:  t = 32'h0028BE53;
        5'd9:  t = 32'h00145F2F;
        5'd10: t = 32'h000A2F98;
        5'd11: t = 32'h000517CC;
        5'd12: t = 32'h00028BE6;
        5'd13: t = 32'h000145F3;
        5'd14: t = 32'h0000A2FA;
        5'd15: t = 32'h0000517D;
        5'd16: t = 32'h000028BE;
        5'd17: t = 32'h0000145F;
        5'd18: t = 32'h00000A30;
        5'd19: t = 32'h00000518;
        5'd20: t = 32'h0000028C;
        5'd21: t = 32'h00000146;
        5'd22: t = 32'h000000A3;
        5'd23: t = 32'h00000051;
        5'd24: t = 32'h00000029;
        5'd25: t = 32'h00000014;
        5'd26: t = 32'h0000000A;
        5'd27: t = 32'h00000005;
        5'd28: t = 32'h00000003;
        5'd29: t = 32'h00000001;
        5'd30: t = 32'h00000001;
        default: t = 32'h00000000;
      endcase
      return t;
    end
  endfunction

endpackage

// ===== hw/rtl/ptsb_if.sv =====
// ptsb_if: valid/ready channel interface, payload type given as a parameter
// depends on nothing

interface ptsb_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ptsb_ctrl.sv =====
// ptsb_ctrl: sequencer for the point-to-scan binning block
// depends on ptsb_pkg

module ptsb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_valid,
  input  logic              out_ready,
  input  ptsb_pkg::stat_t   stat,
  output ptsb_pkg::cmd_t    cmd
);

  ptsb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptsb_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptsb_pkg::ST_CLEAR:  if (stat.clr_done) state_nxt = ptsb_pkg::ST_IDLE;
      ptsb_pkg::ST_IDLE:   if (in_valid) state_nxt = ptsb_pkg::ST_LOAD;
      ptsb_pkg::ST_LOAD:   state_nxt = stat.is_read ? ptsb_pkg::ST_READ : ptsb_pkg::ST_SQUARE;
      ptsb_pkg::ST_SQUARE: state_nxt = ptsb_pkg::ST_CHECK;
      ptsb_pkg::ST_CHECK:  state_nxt = stat.drop_early ? ptsb_pkg::ST_IDLE : ptsb_pkg::ST_ITER;
      ptsb_pkg::ST_ITER:   if (stat.iter_done) state_nxt = ptsb_pkg::ST_ANGLE;
      ptsb_pkg::ST_ANGLE:  state_nxt = stat.drop_angle ? ptsb_pkg::ST_IDLE : ptsb_pkg::ST_BINS;
      ptsb_pkg::ST_BINS:   if (stat.div_done) state_nxt = ptsb_pkg::ST_INDEX;
      ptsb_pkg::ST_INDEX:  if (stat.div_done) state_nxt = ptsb_pkg::ST_READ;
      ptsb_pkg::ST_READ:   state_nxt = ptsb_pkg::ST_WRITE;
      ptsb_pkg::ST_WRITE:  state_nxt = stat.is_read ? ptsb_pkg::ST_OUT : ptsb_pkg::ST_IDLE;
      ptsb_pkg::ST_OUT:    if (!out_valid || out_ready) state_nxt = ptsb_pkg::ST_IDLE;
      default:             state_nxt = ptsb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ptsb_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
      ptsb_pkg::ST_IDLE:   begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ptsb_pkg::ST_LOAD:   cmd.square = 1'b1;
      ptsb_pkg::ST_SQUARE: cmd.init_iter = 1'b1;
      ptsb_pkg::ST_CHECK:  cmd.iter = 1'b0;
      ptsb_pkg::ST_ITER:   cmd.iter = 1'b1;
      ptsb_pkg::ST_ANGLE:  begin
        cmd.angle     = 1'b1;
        cmd.div_start = 1'b1;
      end
      ptsb_pkg::ST_BINS:   begin
        cmd.div_step  = 1'b1;
        cmd.div_start = stat.div_done;
      end
      ptsb_pkg::ST_INDEX:  begin
        cmd.div_step = 1'b1;
        cmd.bin_pick = stat.div_done;
      end
      ptsb_pkg::ST_READ:   cmd.mem_rd = 1'b1;
      ptsb_pkg::ST_WRITE:  begin
        cmd.mem_wr   = 1'b1;
        cmd.out_load = 1'b0;
      end
      ptsb_pkg::ST_OUT:    cmd.out_load = !out_valid || out_ready;
      default:             cmd = '0;
    endcase
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptsb_pkg::ST_CLEAR) |-> !in_ready)
    else $error("request taken during clearing pass");
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while busy");
  a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptsb_pkg::ST_INDEX) |-> stat.div_second)
    else $error("index division without bin count");

endmodule

// ===== hw/rtl/ptsb_dp.sv =====
// ptsb_dp: datapath with filters, squaring, CORDIC, isqrt, divider and the bin memory
// depends on ptsb_pkg

module ptsb_dp #(
  parameter int MAX_BINS     = ptsb_pkg::MAX_BINS_DEF,
  parameter int CORDIC_STEPS = ptsb_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptsb_pkg::cmd_t              cmd,
  output ptsb_pkg::stat_t             stat,
  input  logic                        cfg_we,
  input  logic [ptsb_pkg::KW-1:0]     cfg_idx,
  input  logic [ptsb_pkg::CW-1:0]     cfg_wdata,
  input  logic                        op,
  input  logic signed [ptsb_pkg::CW-1:0] px,
  input  logic signed [ptsb_pkg::CW-1:0] py,
  input  logic signed [ptsb_pkg::CW-1:0] pz,
  input  logic [ptsb_pkg::TW-1:0]     ptag,
  input  logic                        pinv,
  input  logic [ptsb_pkg::BW-1:0]     rbin,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [ptsb_pkg::BW-1:0]     out_bin,
  output logic [ptsb_pkg::CW-1:0]     out_range,
  output logic                        out_nr
);
  localparam int CW  = ptsb_pkg::CW;
  localparam int AW  = ptsb_pkg::AW;
  localparam int SW  = ptsb_pkg::SW;
  localparam int BW  = ptsb_pkg::BW;
  localparam int IW  = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
  localparam int NS  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int XW  = 44;  // 24 bits + 16 scale + growth
  localparam int QW  = 18;  // quotient / dividend width
  localparam int CNTW = 6;

  // configuration registers
  logic signed [CW-1:0] h_lo_r, h_hi_r;
  logic [CW-1:0]        r_lo_r, r_hi_r;
  logic signed [AW-1:0] a0_r, a1_r;
  logic [AW-1:0]        astep_r;
  logic [8:0]           tf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_lo_r  <= 24'sh800000;
      h_hi_r  <= 24'sh7FFFFF;
      r_lo_r  <= '0;
      r_hi_r  <= ptsb_pkg::NO_RET;
      a0_r    <= 17'sh18000;
      a1_r    <= 17'sh08000;
      astep_r <= 17'd182;
      tf_r    <= 9'd15;
    end else if (cfg_we) begin
      unique case (ptsb_pkg::reg_t'(cfg_idx))
        ptsb_pkg::REG_HEIGHT_LOW:  h_lo_r  <= cfg_wdata;
        ptsb_pkg::REG_HEIGHT_HIGH: h_hi_r  <= cfg_wdata;
        ptsb_pkg::REG_RANGE_LOW:   r_lo_r  <= cfg_wdata;
        ptsb_pkg::REG_RANGE_HIGH:  r_hi_r  <= cfg_wdata;
        ptsb_pkg::REG_ANGLE_START: a0_r    <= cfg_wdata[AW-1:0];
        ptsb_pkg::REG_ANGLE_END:   a1_r    <= cfg_wdata[AW-1:0];
        ptsb_pkg::REG_ANGLE_STEP:  astep_r <= cfg_wdata[AW-1:0];
        ptsb_pkg::REG_TAG_FILTER:  tf_r    <= cfg_wdata[8:0];
        default:                   tf_r    <= tf_r;
      endcase
    end
  end

  // captured request
  logic                 op_r, pinv_r;
  logic signed [CW-1:0] x_r, y_r, z_r;
  logic [7:0]           tag_r;
  logic [BW-1:0]        rbin_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op;
      x_r    <= px;
      y_r    <= py;
      z_r    <= pz;
      tag_r  <= ptag;
      pinv_r <= pinv;
      rbin_r <= rbin;
    end
  end

  // squares of x, y and both range bounds, one multiplier each, registered
  logic [SW-1:0] s_r, lo2_r, hi2_r;
  logic [47:0]   xx_r, yy_r;
  always_ff @(posedge clk) begin
    if (cmd.square) begin
      xx_r  <= 48'(x_r * x_r);
      yy_r  <= 48'(y_r * y_r);
      lo2_r <= SW'(r_lo_r * r_lo_r);
      hi2_r <= SW'(r_hi_r * r_hi_r);
    end
    if (cmd.init_iter) s_r <= SW'(xx_r) + SW'(yy_r);
  end

  logic early_drop;
  always_comb begin
    early_drop = pinv_r
              || (tf_r[8] && ((tag_r & tf_r[7:0]) != 8'd0))
              || (z_r > h_hi_r) || (z_r < h_lo_r)
              || (s_r < lo2_r) || (s_r > hi2_r);
  end

  // CORDIC vectoring, one step a cycle; isqrt runs alongside, one bit pair a cycle
  logic signed [XW-1:0] cx_r, cy_r;
  logic signed [35:0]   acc_r;
  logic [CNTW-1:0]      it_r;
  logic                 org_r;
  logic [SW+1:0]        rem_r;
  logic [SW+1:0]        root_r;
  logic [SW+1:0]        bit_r;
  logic                 sq_run;

  logic signed [XW-1:0] sx, sy, dx, dy;
  logic signed [35:0]   at;
  logic [SW+1:0]        trial;

  always_comb begin
    sx    = XW'(x_r) <<< 16;
    sy    = XW'(y_r) <<< 16;
    dx    = cy_r >>> it_r;
    dy    = cx_r >>> it_r;
    at    = 36'(ptsb_pkg::atan_turn(it_r[4:0]));
    trial = root_r + bit_r;
  end

  assign sq_run = (bit_r != '0);

  always_ff @(posedge clk) begin
    if (cmd.init_iter) begin
      it_r   <= '0;
      org_r  <= (x_r == '0) && (y_r == '0);
      rem_r  <= (SW+2)'(xx_r) + (SW+2)'(yy_r);
      root_r <= '0;
      bit_r  <= (SW+2)'(1) << 48;
      if (x_r < 0) begin
        if (y_r >= 0) begin
          cx_r <= sy;  cy_r <= -sx;  acc_r <= 36'sh040000000;
        end else begin
          cx_r <= -sy; cy_r <= sx;   acc_r <= -36'sh040000000;
        end
      end else begin
        cx_r <= sx;  cy_r <= sy;  acc_r <= '0;
      end
    end else if (cmd.iter) begin
      if (it_r < CNTW'(NS)) begin
        it_r <= it_r + 1'b1;
        if (cy_r >= 0) begin
          cx_r <= cx_r + dx; cy_r <= cy_r - dy; acc_r <= acc_r + at;
        end else begin
          cx_r <= cx_r - dx; cy_r <= cy_r + dy; acc_r <= acc_r - at;
        end
      end
      if (sq_run) begin
        if (rem_r >= trial) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
  end

  // angle and window test
  logic signed [35:0] acc_rnd;
  logic signed [19:0] ang_w;
  logic signed [AW:0] ang_c;
  logic signed [AW:0] ang_r;
  always_comb begin
    acc_rnd = (acc_r + 36'sd32768) >>> 16;
    ang_w   = 20'(acc_rnd);
    if (org_r) ang_c = '0;
    else if (ang_w > 20'sd32768) ang_c = 18'sd32768;
    else if (ang_w < -20'sd32768) ang_c = -18'sd32768;
    else ang_c = 18'(ang_w);
  end
  always_ff @(posedge clk) if (cmd.angle) ang_r <= ang_c;

  logic angle_drop;
  assign angle_drop = (ang_c < 18'(a0_r)) || (ang_c > 18'(a1_r));

  // restoring divider, used for bin count then index
  logic [AW-1:0]   stp;
  logic [QW-1:0]   dq_r;
  logic [QW:0]     dr_r;
  logic [CNTW-1:0] dc_r;
  logic            second_r;
  logic [QW-1:0]   nbins_r;
  logic            nzero_r;
  logic [QW:0]     dr_sh;
  logic signed [AW+1:0] span;
  logic [QW-1:0]   cnt_num;

  assign stp    = (astep_r == '0) ? AW'(1) : astep_r;
  assign span   = 19'(a1_r) - 19'(a0_r);
  assign cnt_num = QW'(span) + QW'(stp) - QW'(1);
  assign dr_sh  = {dr_r[QW-1:0], dq_r[QW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else if (cmd.div_start) begin
      dr_r <= '0;
      dc_r <= '0;
      if (cmd.angle) begin
        second_r <= 1'b0;
        nzero_r  <= !(span > 0);
        dq_r     <= cnt_num;
      end else begin
        second_r <= 1'b1;
        nbins_r  <= dq_r;
        dq_r     <= QW'(ang_r - 18'(a0_r));
      end
    end else if (cmd.div_step && dc_r < CNTW'(QW)) begin
      dc_r <= dc_r + 1'b1;
      if (dr_sh >= (QW+1)'(stp)) begin
        dr_r <= dr_sh - (QW+1)'(stp);
        dq_r <= {dq_r[QW-2:0], 1'b1};
      end else begin
        dr_r <= dr_sh;
        dq_r <= {dq_r[QW-2:0], 1'b0};
      end
    end
  end

  logic [QW-1:0] last_b;
  logic [IW-1:0] idx_c;
  logic [IW-1:0] idx_r;
  always_comb begin
    if (nzero_r) last_b = '0;
    else if (nbins_r > QW'(MAX_BINS)) last_b = QW'(MAX_BINS - 1);
    else last_b = nbins_r - QW'(1);
    idx_c = (dq_r > last_b) ? IW'(last_b) : IW'(dq_r);
  end

  // bin memory with a clearing pass after reset
  logic [CW-1:0] mem [MAX_BINS];
  logic [IW:0]   clr_r;
  logic [CW-1:0] rd_r;
  logic [IW-1:0] addr;
  logic          rd_ok_r;
  logic          rbin_ok;

  assign rbin_ok = (32'(rbin_r) < MAX_BINS);
  assign addr    = op_r ? IW'(rbin_r) : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bin_pick) idx_r <= idx_c;
    if (cmd.clr_step) begin
      mem[clr_r[IW-1:0]] <= ptsb_pkg::NO_RET;
    end else if (cmd.mem_wr) begin
      if (op_r) begin
        if (rbin_ok) mem[addr] <= ptsb_pkg::NO_RET;
      end else if (root_r[CW-1:0] < rd_r) begin
        mem[addr] <= root_r[CW-1:0];
      end
    end
    if (cmd.mem_rd) begin
      rd_r    <= mem[addr];
      rd_ok_r <= rbin_ok;
    end
  end

  // output register
  logic          ov_r;
  logic [BW-1:0] ob_r;
  logic [CW-1:0] or_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ob_r <= rbin_r;
      or_r <= rd_ok_r ? rd_r : ptsb_pkg::NO_RET;
    end
  end

  assign out_valid = ov_r;
  assign out_bin   = ob_r;
  assign out_range = or_r;
  assign out_nr    = (or_r == ptsb_pkg::NO_RET);

  always_comb begin
    stat.clr_done   = (clr_r == (IW+1)'(MAX_BINS - 1));
    stat.is_read    = op_r;
    stat.drop_early = early_drop;
    stat.drop_angle = angle_drop;
    stat.iter_done  = (it_r >= CNTW'(NS)) && !sq_run;
    stat.div_done   = (dc_r == CNTW'(QW));
    stat.div_second = second_r;
  end

  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr && !op_r |-> (root_r[SW+1:CW] == '0))
    else $error("range root wider than field");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bin_pick |=> (32'(idx_r) < MAX_BINS))
    else $error("bin index out of store");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(or_r))
    else $error("result changed while stalled");

endmodule

// ===== hw/rtl/point_to_scan_binning.sv =====
// point_to_scan_binning: top level, joins sequencer and datapath to the channels
// depends on ptsb_pkg, ptsb_if, ptsb_ctrl, ptsb_dp
//
//  channel  | direction | payload
//  in_ch    | sink      | opcode, pos_x, pos_y, pos_z, point_tag, point_invalid, read_bin
//  out_ch   | source    | out_bin, out_range, no_return
//  cfg_*    | write     | cfg_we, cfg_idx, cfg_wdata (8 registers)
//
// one request at a time; a readout passes through capture, memory read, write and the output register
// an insert passes through capture, squaring and the filters, the 20-step CORDIC beside
// the 25-step isqrt, the window test, two divider passes (bin count, then index) and the update
// early drops free the block after the filter check, window drops after the window test
// after reset a clearing pass writes every bin before in_ch is ready
// a stalled result holds in the output register; the next readout waits until it leaves

module point_to_scan_binning #(
  parameter int MAX_BINS     = ptsb_pkg::MAX_BINS_DEF,
  parameter int CORDIC_STEPS = ptsb_pkg::CORDIC_STEPS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  ptsb_if.sink                     in_ch,
  ptsb_if.source                   out_ch,
  input logic                      cfg_we,
  input logic [ptsb_pkg::KW-1:0]   cfg_idx,
  input logic [ptsb_pkg::CW-1:0]   cfg_wdata
);

  ptsb_pkg::cmd_t  cmd;
  ptsb_pkg::stat_t stat;
  logic            ov;

  ptsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (ov),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptsb_dp #(
    .MAX_BINS     (MAX_BINS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .op        (in_ch.data.opcode),
    .px        (in_ch.data.pos_x),
    .py        (in_ch.data.pos_y),
    .pz        (in_ch.data.pos_z),
    .ptag      (in_ch.data.point_tag),
    .pinv      (in_ch.data.point_invalid),
    .rbin      (in_ch.data.read_bin),
    .out_ready (out_ch.ready),
    .out_valid (ov),
    .out_bin   (out_ch.data.out_bin),
    .out_range (out_ch.data.out_range),
    .out_nr    (out_ch.data.no_return)
  );

  assign out_ch.valid = ov;

endmodule

// ===== dv/ptsb_tb_pkg.sv =====
// ptsb_tb_pkg: request and result payload types for the binning testbench
// depends on ptsb_pkg

package ptsb_tb_pkg;
  import ptsb_pkg::*;

  typedef struct packed {
    op_t               opcode;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [7:0]        point_tag;
    logic              point_invalid;
    logic [9:0]        read_bin;
  } req_t;

  typedef struct packed {
    logic [9:0]  out_bin;
    logic [23:0] out_range;
    logic        no_return;
  } scan_t;
endpackage

// ===== dv/ptsb_checker.sv =====
// ptsb_checker: tracks register writes, predicts bin readouts and checks the result channel
// depends on ptsb_pkg, ptsb_tb_pkg, ptsb_if

module ptsb_checker #(
  parameter int MAX_BINS     = 1024,
  parameter int CORDIC_STEPS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ptsb_if                       in_mon,
  ptsb_if                       out_mon,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_idx,
  input  logic [23:0]           cfg_wdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ptsb_pkg::*;
  import ptsb_tb_pkg::*;

  // atan(2^-i) in 2^-32 turn
  localparam longint ATAN_LUT [32] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
    64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
  };

  logic signed [23:0] h_lo, h_hi;
  logic [23:0]        r_lo, r_hi;
  logic signed [16:0] a_start, a_end;
  logic [16:0]        a_step;
  logic [8:0]         tag_cfg;
  logic [23:0]        nearest [MAX_BINS];
  scan_t              expected_scans [$];

  assign pending = expected_scans.size();

  function automatic longint floor_sqrt(longint v);
    longint root, b;
    root = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >>> 1) + b;
      end else begin
        root = root >>> 1;
      end
      b = b >>> 2;
    end
    return root;
  endfunction

  function automatic longint point_angle(longint x0, longint y0);
    longint x, y, acc, t, dx, dy, a;
    int n;
    x = x0 * 65536;
    y = y0 * 65536;
    acc = 0;
    n = CORDIC_STEPS > 32 ? 32 : CORDIC_STEPS;
    if (x0 == 0 && y0 == 0) return 0;
    // left half plane: pre-rotate a quarter turn
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = 64'sd1 <<< 30;
      end else begin
        x = -y; y = t; acc = -(64'sd1 <<< 30);
      end
    end
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += ATAN_LUT[i];
      end else begin
        x -= dx; y += dy; acc -= ATAN_LUT[i];
      end
    end
    a = (acc + 32768) >>> 16;
    if (a > 32768) a = 32768;
    if (a < -32768) a = -32768;
    return a;
  endfunction

  function automatic void bin_point(req_t rq);
    longint x, y, z, s, lo, hi, a0, a1, stp, n, last, idx, ang, r;
    x = rq.pos_x; y = rq.pos_y; z = rq.pos_z;
    a0 = a_start; a1 = a_end;
    stp = (a_step == 0) ? 1 : a_step;
    lo = r_lo; hi = r_hi;
    if (rq.point_invalid) return;
    if (tag_cfg[8] && ((rq.point_tag & tag_cfg[7:0]) != 0)) return;
    if (z > h_hi || z < h_lo) return;
    s = x * x + y * y;
    if (s < lo * lo || s > hi * hi) return;
    ang = point_angle(x, y);
    if (ang < a0 || ang > a1) return;
    n = (a1 > a0) ? (a1 - a0 + stp - 1) / stp : 0;
    last = (n == 0) ? 0 : ((n > MAX_BINS ? MAX_BINS : n) - 1);
    idx = (ang - a0) / stp;
    if (idx > last) idx = last;
    r = floor_sqrt(s);
    if (r < nearest[idx]) nearest[idx] = r[23:0];
  endfunction

  always @(posedge clk) begin
    scan_t exp_s, got;
    if (!rst_n) begin
      h_lo <= 24'h800000; h_hi <= 24'h7FFFFF;
      r_lo <= '0;         r_hi <= 24'hFFFFFF;
      a_start <= 17'h18000; a_end <= 17'h08000;
      a_step <= 17'd182;  tag_cfg <= 9'd15;
      for (int i = 0; i < MAX_BINS; i++) nearest[i] = NO_RET;
      expected_scans.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_t'(cfg_idx))
          REG_HEIGHT_LOW:  h_lo <= cfg_wdata;
          REG_HEIGHT_HIGH: h_hi <= cfg_wdata;
          REG_RANGE_LOW:   r_lo <= cfg_wdata;
          REG_RANGE_HIGH:  r_hi <= cfg_wdata;
          REG_ANGLE_START: a_start <= cfg_wdata[16:0];
          REG_ANGLE_END:   a_end <= cfg_wdata[16:0];
          REG_ANGLE_STEP:  a_step <= cfg_wdata[16:0];
          REG_TAG_FILTER:  tag_cfg <= cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.data.opcode == OP_INSERT) begin
          bin_point(in_mon.data);
        end else begin
          exp_s.out_bin = in_mon.data.read_bin;
          exp_s.out_range = NO_RET;
          if (in_mon.data.read_bin < MAX_BINS) begin
            exp_s.out_range = nearest[in_mon.data.read_bin];
            nearest[in_mon.data.read_bin] = NO_RET;
          end
          exp_s.no_return = (exp_s.out_range == NO_RET);
          expected_scans.push_back(exp_s);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_scans.size() == 0) begin
          $display("%0t: unexpected scan result bin=%0d range=%0d no_return=%0b",
                   $time, got.out_bin, got.out_range, got.no_return);
          fail_count <= fail_count + 1;
        end else begin
          exp_s = expected_scans.pop_front();
          if (got !== exp_s) begin
            $display("%0t: scan mismatch exp bin=%0d range=%0d nr=%0b got bin=%0d range=%0d nr=%0b",
                     $time, exp_s.out_bin, exp_s.out_range, exp_s.no_return,
                     got.out_bin, got.out_range, got.no_return);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb_point_to_scan_binning.sv =====
// tb_point_to_scan_binning: stimulus, clock/reset and verdict for the binning block
// depends on ptsb_pkg, ptsb_tb_pkg, ptsb_if, ptsb_checker, point_to_scan_binning

module tb_point_to_scan_binning;
  timeunit 1ns;
  timeprecision 1ps;
  import ptsb_pkg::*;
  import ptsb_tb_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [23:0] cfg_wdata = '0;
  int          fail_count, pending;
  int          send_idle_pct = 0, sink_stall_pct = 0;
  int          read_span = 361;
  int          scale_min = 0;
  int          reads_sent = 0, inserts_sent = 0;
  longint      cycles = 0;
  logic signed [23:0] z_lo = 24'h800000, z_hi = 24'h7FFFFF;

  ptsb_if #(.payload_t(req_t))  in_ch (clk);
  ptsb_if #(.payload_t(scan_t)) out_ch (clk);

  point_to_scan_binning dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  ptsb_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // write enable stays high across back-to-back writes; the caller drops it
  task automatic write_reg(reg_t idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    // an insert may still be in flight after the last readout
    repeat (120) @(posedge clk);
  endtask

  task automatic send_req(req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= rq;
    do @(posedge clk); while (!in_ch.ready);
    if (rq.opcode == OP_READ) reads_sent++;
    else inserts_sent++;
  endtask

  function automatic req_t mk_point(int x, int y, int z, int tag, bit inval);
    req_t rq;
    rq = '0;
    rq.opcode = OP_INSERT;
    rq.pos_x = 24'(x); rq.pos_y = 24'(y); rq.pos_z = 24'(z);
    rq.point_tag = 8'(tag);
    rq.point_invalid = inval;
    rq.read_bin = 10'($urandom);
    return rq;
  endfunction

  function automatic req_t mk_read(int b);
    req_t rq;
    rq = '0;
    rq.opcode = OP_READ;
    rq.read_bin = 10'(b);
    rq.pos_x = 24'($urandom); rq.pos_y = 24'($urandom); rq.pos_z = 24'($urandom);
    rq.point_tag = 8'($urandom);
    return rq;
  endfunction

  function automatic req_t rand_req();
    req_t rq;
    int sh, zz;
    if ($urandom_range(99) < 40) begin
      rq = mk_read($urandom_range(99) < 85 ? $urandom_range(read_span - 1) : $urandom_range(1023));
    end else begin
      sh = $urandom_range(23, scale_min);
      zz = (z_hi >= z_lo && $urandom_range(9) < 8) ?
           int'(z_lo) + int'($urandom_range(int'(z_hi) - int'(z_lo))) : int'($urandom);
      rq = mk_point(int'($signed($urandom)) >>> (8 + sh), int'($signed($urandom)) >>> (8 + sh),
                    zz, ($urandom_range(3) == 0) ? $urandom : 0, $urandom_range(9) == 0);
    end
    return rq;
  endfunction

  task automatic apply_cfg(int hl, int hh, int rl, int rh, int a0, int a1, int stp, int tf,
                           int span);
    write_reg(REG_HEIGHT_LOW, 24'(hl));
    write_reg(REG_HEIGHT_HIGH, 24'(hh));
    write_reg(REG_RANGE_LOW, 24'(rl));
    write_reg(REG_RANGE_HIGH, 24'(rh));
    write_reg(REG_ANGLE_START, 24'(a0));
    write_reg(REG_ANGLE_END, 24'(a1));
    write_reg(REG_ANGLE_STEP, 24'(stp));
    write_reg(REG_TAG_FILTER, 24'(tf));
    cfg_we <= 1'b0;
    z_lo = 24'(hl); z_hi = 24'(hh);
    read_span = span;
  endtask

  task automatic run_random(int count, int mode);
    for (int i = 0; i < count; i++) begin
      // idle mode changes every few dozen requests, with plain stretches between
      case ((i / 40 + mode) % 4)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 81; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 81; end
        default: begin send_idle_pct = 12; sink_stall_pct = 12; end
      endcase
      send_req(rand_req());
    end
    in_ch.valid <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // the block clears every bin before taking requests
    repeat (MAX_BINS_DEF + 64) @(posedge clk);

    apply_cfg(-8388608, 8388607, 0, 16777215, -32768, 32768, 182, 15, 361);
    // directed: extremes, origin, filters, both half planes
    send_req(mk_point(0, 0, 0, 0, 0));
    send_req(mk_point(-8388608, -8388608, -8388608, 0, 0));
    send_req(mk_point(8388607, 8388607, 8388607, 0, 0));
    send_req(mk_point(-1000, 0, 5, 0, 0));
    send_req(mk_point(-1000, -1, 5, 0, 0));
    send_req(mk_point(8388607, -8388608, 0, 0, 0));
    send_req(mk_point(300, 40, 0, 8'hFF, 1));
    send_req(mk_point(3, -4, 0, 8'h01, 0));
    send_req(mk_read(0));
    send_req(mk_read(180));
    send_req(mk_read(181));
    send_req(mk_read(360));
    send_req(mk_read(90));
    send_req(mk_read(270));
    send_req(mk_read(1023));
    send_req(mk_read(45));
    send_req(mk_read(0));
    in_ch.valid <= 1'b0;
    drain();
    scale_min = 0;
    run_random(280, 0);

    // tight bands, tag drop on
    apply_cfg(-1000, 1000, 100, 5000, -8192, 8192, 64, 9'h1F0, 256);
    send_req(mk_point(100, 0, -1000, 0, 0));
    send_req(mk_point(5000, 0, 1000, 0, 0));
    send_req(mk_point(99, 0, 0, 0, 0));
    send_req(mk_point(200, 0, 0, 8'h10, 0));
    send_req(mk_read(128));
    in_ch.valid <= 1'b0;
    drain();
    scale_min = 10;
    run_random(280, 1);

    // zero step behaves as one, full tag mask
    apply_cfg(-8388608, 8388607, 0, 16777215, -512, 511, 0, 9'h1FF, 1023);
    scale_min = 4;
    run_random(280, 2);

    // widest step: one bin
    apply_cfg(-4096, 4096, 0, 16777215, -32768, 32768, 65536, 0, 4);
    scale_min = 0;
    run_random(220, 3);

    // more bins than the store holds, clamped to the last
    apply_cfg(-8388608, 8388607, 1, 16777215, -32768, 32768, 16, 9'h100, 1024);
    run_random(300, 0);

    // inverted bands and window drop everything
    apply_cfg(1000, -1000, 5000, 100, 8192, -8192, 1, 9'h0FF, 256);
    run_random(200, 1);
    apply_cfg(-8388608, 8388607, 16777215, 16777215, 32768, 32768, 1, 0, 8);
    run_random(150, 2);

    repeat (60) @(posedge clk);
    $display("covered %0d point inserts and %0d bin readouts over seven register settings",
             inserts_sent, reads_sent);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
